### sv/mht_pkg.sv
// Shared types and constants for the missing-HT accumulator.
// Holds the queue entry and status types, register codes and CORDIC tables.
// No dependencies.
package mht_pkg;

	// Configuration port geometry and register codes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_JET_PT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_JET_ETA = 2'd1;

	// Register reset values.
	localparam logic [15:0] MIN_JET_PT_RST  = 16'd120;
	localparam logic [8:0]  MAX_JET_ETA_RST = 9'd240;

	// Result field widths and saturation limits.
	localparam int OUT_W = 24;
	localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

	// Queue between the accumulator and the CORDIC unit.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	// CORDIC datapath: 24-bit inputs scaled by 2^16 plus growth headroom.
	localparam int CORDIC_W   = 43;
	localparam int ANGLE_W    = 34;
	localparam int ATAN_N     = 24;
	localparam int ATAN_IDX_W = 5;
	localparam int MAG_IN_W   = CORDIC_W - 9;
	localparam int PROD_W     = 64;
	localparam logic [29:0] MAG_GAIN = 30'd652032874;
	localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 34'sd1073741824;

	// atan(2^-i) with pi = 2^31.
	localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// One closed event waiting for the CORDIC unit.
	typedef struct packed {
		logic signed [OUT_W-1:0] ox;
		logic signed [OUT_W-1:0] oy;
	} vec_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

### sv/mht_intf.sv
// Channel interfaces: jet items in, missing-HT result items out.
// Depends on mht_pkg for field widths.
interface jet_if;
	import mht_pkg::*;
	logic               valid;
	logic               ready;
	logic signed [16:0] jet_px;
	logic signed [16:0] jet_py;
	logic        [15:0] jet_pt;
	logic signed [9:0]  jet_eta;
	logic               jet_valid;
	logic               last_jet;

	modport source (output valid, jet_px, jet_py, jet_pt, jet_eta, jet_valid, last_jet,
		input ready);
	modport sink (input valid, jet_px, jet_py, jet_pt, jet_eta, jet_valid, last_jet,
		output ready);
endinterface

interface mht_if;
	import mht_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] mht_px;
	logic signed [OUT_W-1:0] mht_py;
	logic        [OUT_W-1:0] mht_magnitude;
	logic signed [15:0]      mht_angle;

	modport source (output valid, mht_px, mht_py, mht_magnitude, mht_angle, input ready);
	modport sink (input valid, mht_px, mht_py, mht_magnitude, mht_angle, output ready);
endinterface

### sv/mht_front.sv
// Front end: jet selection, saturating px/py accumulation and event close.
// Holds the two threshold registers. Depends on mht_pkg and jet_if.
module mht_front #(
	parameter int ACC_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	jet_if.sink                             jet,
	input  logic                            cfg_we,
	input  logic [mht_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mht_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  mht_pkg::q_stat_t                q_stat,
	output logic                            push,
	output mht_pkg::vec_t                   push_data
);
	import mht_pkg::*;

	localparam int SAT_W = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;
	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	logic [15:0]                   min_jet_pt_q;
	logic [8:0]                    max_jet_eta_q;
	logic signed [ACC_WIDTH-1:0]   sum_x_q;
	logic signed [ACC_WIDTH-1:0]   sum_y_q;
	logic [9:0]                    abs_eta;
	logic                          selected;
	logic                          accept;
	logic signed [ACC_WIDTH:0]     diff_x;
	logic signed [ACC_WIDTH:0]     diff_y;
	logic signed [ACC_WIDTH-1:0]   new_x;
	logic signed [ACC_WIDTH-1:0]   new_y;
	logic signed [SAT_W-1:0]       wide_x;
	logic signed [SAT_W-1:0]       wide_y;

	// Configuration registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_jet_pt_q  <= MIN_JET_PT_RST;
			max_jet_eta_q <= MAX_JET_ETA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_JET_PT:  min_jet_pt_q  <= cfg_data[15:0];
				REG_MAX_JET_ETA: max_jet_eta_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// The queue only fills on event close; holding off every item keeps it simple.
	assign jet.ready = !q_stat.full;
	assign accept    = jet.valid && jet.ready;

	// Jet selection: pt strictly above threshold, |eta| strictly below limit.
	assign abs_eta  = jet.jet_eta[9] ? 10'(-jet.jet_eta) : 10'(jet.jet_eta);
	assign selected = jet.jet_valid && (jet.jet_pt > min_jet_pt_q)
		&& (abs_eta < {1'b0, max_jet_eta_q});

	// Subtract the jet with one guard bit, then clamp to the accumulator range.
	assign diff_x = {sum_x_q[ACC_WIDTH-1], sum_x_q} - (ACC_WIDTH+1)'(jet.jet_px);
	assign diff_y = {sum_y_q[ACC_WIDTH-1], sum_y_q} - (ACC_WIDTH+1)'(jet.jet_py);

	always_comb begin
		new_x = sum_x_q;
		new_y = sum_y_q;
		if (selected) begin
			if (diff_x[ACC_WIDTH] != diff_x[ACC_WIDTH-1]) begin
				new_x = diff_x[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
			end else begin
				new_x = diff_x[ACC_WIDTH-1:0];
			end
			if (diff_y[ACC_WIDTH] != diff_y[ACC_WIDTH-1]) begin
				new_y = diff_y[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
			end else begin
				new_y = diff_y[ACC_WIDTH-1:0];
			end
		end
	end

	// Clamp the event sums to the 24-bit result range.
	assign wide_x = SAT_W'(new_x);
	assign wide_y = SAT_W'(new_y);

	always_comb begin
		if (wide_x > SAT_W'(OUT_MAX)) begin
			push_data.ox = OUT_MAX;
		end else if (wide_x < SAT_W'(OUT_MIN)) begin
			push_data.ox = OUT_MIN;
		end else begin
			push_data.ox = wide_x[OUT_W-1:0];
		end
		if (wide_y > SAT_W'(OUT_MAX)) begin
			push_data.oy = OUT_MAX;
		end else if (wide_y < SAT_W'(OUT_MIN)) begin
			push_data.oy = OUT_MIN;
		end else begin
			push_data.oy = wide_y[OUT_W-1:0];
		end
	end

	assign push = accept && jet.last_jet;

	// Running sums, cleared when an event closes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (accept) begin
			if (jet.last_jet) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
			end else begin
				sum_x_q <= new_x;
				sum_y_q <= new_y;
			end
		end
	end

endmodule

### sv/mht_queue.sv
// Small event queue between the accumulator and the CORDIC unit.
// Holds closed-event sums. Depends on mht_pkg.
module mht_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mht_pkg::vec_t    push_data,
	input  logic             pop,
	output mht_pkg::vec_t    head,
	output mht_pkg::q_stat_t q_stat
);
	import mht_pkg::*;

	vec_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign q_stat.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### sv/mht_cordic.sv
// Back end: iterative vectoring CORDIC, gain correction and result register.
// Takes closed-event sums from the queue. Depends on mht_pkg and mht_if.
module mht_cordic #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mht_pkg::vec_t    head,
	input  mht_pkg::q_stat_t q_stat,
	output logic             pop,
	mht_if.source            mht
);
	import mht_pkg::*;

	localparam int IW = $clog2(CORDIC_ITERATIONS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ITER = 4'b0010,
		ST_MUL  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [IW-1:0]               iter_q;
	logic signed [CORDIC_W-1:0]  x_q;
	logic signed [CORDIC_W-1:0]  y_q;
	logic signed [ANGLE_W-1:0]   z_q;
	logic signed [OUT_W-1:0]     ox_q;
	logic signed [OUT_W-1:0]     oy_q;
	logic                        zero_q;
	logic [PROD_W-1:0]           prod_q;
	logic                        out_vld_q;
	logic signed [OUT_W-1:0]     out_px_q;
	logic signed [OUT_W-1:0]     out_py_q;
	logic [OUT_W-1:0]            out_mag_q;
	logic signed [15:0]          out_ang_q;

	logic signed [CORDIC_W-1:0]  x0;
	logic signed [CORDIC_W-1:0]  y0;
	logic signed [CORDIC_W-1:0]  x_init;
	logic signed [CORDIC_W-1:0]  y_init;
	logic signed [ANGLE_W-1:0]   z_init;
	logic signed [CORDIC_W-1:0]  dx;
	logic signed [CORDIC_W-1:0]  dy;
	logic signed [ANGLE_W-1:0]   step_ang;
	logic                        y_pos;
	logic [MAG_IN_W-1:0]         mag_in;
	logic [PROD_W-1:0]           prod_c;
	logic [PROD_W-1:0]           rounded;
	logic [OUT_W-1:0]            mag_c;
	logic signed [ANGLE_W-1:0]   ang_rnd;
	logic                        out_free;

	// Start a new event only when idle and one is waiting.
	assign pop = (state_q == ST_IDLE) && !q_stat.empty;

	// Scale by 2^16 and pre-rotate a left-half-plane vector by a quarter turn.
	assign x0 = {{(CORDIC_W-OUT_W-16){head.ox[OUT_W-1]}}, head.ox, 16'h0000};
	assign y0 = {{(CORDIC_W-OUT_W-16){head.oy[OUT_W-1]}}, head.oy, 16'h0000};

	always_comb begin
		x_init = x0;
		y_init = y0;
		z_init = '0;
		if (x0[CORDIC_W-1]) begin
			if (!y0[CORDIC_W-1]) begin
				x_init = y0;
				y_init = -x0;
				z_init = QUARTER_TURN;
			end else begin
				x_init = -y0;
				y_init = x0;
				z_init = -QUARTER_TURN;
			end
		end
	end

	// One micro-rotation per cycle through the shared shifters and adders.
	assign dx       = y_q >>> iter_q;
	assign dy       = x_q >>> iter_q;
	assign step_ang = ANGLE_W'(ATAN_TAB[ATAN_IDX_W'(iter_q)]);
	assign y_pos    = !y_q[CORDIC_W-1] && (y_q != '0);

	// Gain correction on x shifted down by eight; negative x counts as zero.
	assign mag_in = x_q[CORDIC_W-1] ? '0 : MAG_IN_W'(x_q[CORDIC_W-2:8]);
	assign prod_c = PROD_W'(mag_in) * PROD_W'(MAG_GAIN);

	// Round half up, saturate the magnitude; round the angle to pi = 2^15.
	assign rounded = prod_q + (PROD_W'(1) << 37);
	assign mag_c   = (rounded[PROD_W-1:38 + OUT_W] != '0) ? {OUT_W{1'b1}}
		: rounded[38 + OUT_W - 1:38];
	assign ang_rnd = z_q + ANGLE_W'(32768);

	assign out_free = !out_vld_q || mht.ready;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_ITER;
						iter_q  <= '0;
					end
				end
				ST_ITER: begin
					if (iter_q == IW'(CORDIC_ITERATIONS - 1)) begin
						state_q <= ST_MUL;
					end
					iter_q <= iter_q + 1'b1;
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// CORDIC datapath registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			x_q    <= x_init;
			y_q    <= y_init;
			z_q    <= z_init;
			ox_q   <= head.ox;
			oy_q   <= head.oy;
			zero_q <= (head.ox == '0) && (head.oy == '0);
		end else if (state_q == ST_ITER) begin
			if (y_pos) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + step_ang;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - step_ang;
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_c;
		end
	end

	// Output register: the next event computes while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_vld_q <= 1'b1;
		end else if (mht.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			out_px_q  <= ox_q;
			out_py_q  <= oy_q;
			out_mag_q <= zero_q ? '0 : mag_c;
			out_ang_q <= zero_q ? '0 : ang_rnd[31:16];
		end
	end

	assign mht.valid         = out_vld_q;
	assign mht.mht_px        = out_px_q;
	assign mht.mht_py        = out_py_q;
	assign mht.mht_magnitude = out_mag_q;
	assign mht.mht_angle     = out_ang_q;

endmodule

### sv/missing_ht_accumulator_unit.sv
// Missing-HT accumulator top level: front end, event queue and CORDIC back end.
// Depends on mht_pkg, jet_if, mht_if, mht_front, mht_queue and mht_cordic.
//
// Jets enter at one item per clock cycle. Each selected jet (pt above
// min_jet_pt, |eta| below max_jet_eta) is subtracted from saturating px/py
// sums; the item marked last_jet closes the event, and its sums go into a
// four-entry queue. A single iterative CORDIC unit drains the queue, one
// micro-rotation per cycle, taking each event through load, iterations,
// gain multiply and round in that order, and it loads the next event only
// once the last has left the round step. Jet input stalls only while four
// closed events wait in the queue.
// A finished result waits in an output register while the next event runs.
module missing_ht_accumulator_unit #(
	parameter int ACC_WIDTH         = 24,
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	jet_if.sink                            jet,
	mht_if.source                          mht,
	input  logic                           cfg_we,
	input  logic [mht_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mht_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mht_pkg::*;

	logic    push;
	logic    pop;
	vec_t    push_data;
	vec_t    head;
	q_stat_t q_stat;

	// Selection and accumulation.
	mht_front #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.jet       (jet),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// Closed events awaiting the CORDIC unit.
	mht_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// Magnitude and azimuth.
	mht_cordic #(
		.CORDIC_ITERATIONS (CORDIC_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.mht    (mht)
	);

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for missing_ht_accumulator_unit: jet items in, one missing-HT item out
// per event. It depends on mht_pkg, the jet_if and mht_if channel interfaces, and the RTL top.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mht_pkg::*;

	localparam int ACC_W         = 24;
	localparam int CORDIC_ITERS  = 16;
	// Cycles to let the back end settle once the last expected item has come.
	localparam int SETTLE_CYCLES = 2 * (CORDIC_ITERS + 4) + 8;

	// Register indexes past the two real cut registers.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// atan(2^-i) with a half turn equal to 2^31.
	localparam longint ATAN_STEP [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};
	// round(2^30 / CORDIC gain).
	localparam logic [63:0] GAIN_COMP = 64'd652032874;

	typedef struct packed {
		logic signed [16:0] px;
		logic signed [16:0] py;
		logic        [15:0] pt;
		logic signed [9:0]  eta;
		logic               has_jet;
		logic               last;
	} jet_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] px;
		logic signed [OUT_W-1:0] py;
		logic        [OUT_W-1:0] mag;
		logic signed [15:0]      ang;
	} mht_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	jet_if jet_ch ();
	mht_if mht_ch ();

	missing_ht_accumulator_unit #(
		.ACC_WIDTH        (ACC_W),
		.CORDIC_ITERATIONS(CORDIC_ITERS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.jet      (jet_ch),
		.mht      (mht_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Shadow of the block: cut registers and running sums.
	logic [15:0] cut_pt;
	logic [8:0]  cut_eta;
	longint      acc_x;
	longint      acc_y;

	mht_t expected_mht[$];
	bit   idle_en;
	int   rx_stall_left = 0;
	int   n_jets;
	int   n_events_checked;
	int   n_cut_settings;
	int   n_mismatch;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("missing_ht_accumulator_unit verification failed");
		$finish;
	end

	function automatic longint clamp_signed(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	// Vectoring CORDIC on the event sums: magnitude and azimuth.
	function automatic void polar_of(input longint vx, input longint vy,
		output logic [OUT_W-1:0] mag, output logic signed [15:0] ang);
		longint      x;
		longint      y;
		longint      z;
		longint      t;
		longint      dx;
		longint      dy;
		logic [63:0] m;
		if (vx == 0 && vy == 0) begin
			mag = '0;
			ang = '0;
			return;
		end
		x = vx * 65536;
		y = vy * 65536;
		z = 0;
		// Left half plane: a quarter turn first.
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 1073741824;
			end else begin
				x = -y;
				y = t;
				z = -1073741824;
			end
		end
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_STEP[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_STEP[i];
			end
		end
		if (x < 0) x = 0;
		m = (64'(x) >> 8) * GAIN_COMP;
		m = (m + (64'd1 << 37)) >> 38;
		if (m > 64'hFF_FFFF) m = 64'hFF_FFFF;
		mag = m[OUT_W-1:0];
		ang = 16'((z + 32768) >>> 16);
	endfunction

	// Fold one accepted jet into the sums; on the closing item form the result.
	function automatic bit fold_jet(input jet_t j, output mht_t r);
		int     abs_eta;
		longint ox;
		longint oy;
		abs_eta = ($signed(j.eta) < 0) ? -int'($signed(j.eta)) : int'($signed(j.eta));
		if (j.has_jet && j.pt > cut_pt && abs_eta < int'(cut_eta)) begin
			acc_x = clamp_signed(acc_x - longint'($signed(j.px)), ACC_W);
			acc_y = clamp_signed(acc_y - longint'($signed(j.py)), ACC_W);
		end
		if (!j.last) return 1'b0;
		ox = clamp_signed(acc_x, OUT_W);
		oy = clamp_signed(acc_y, OUT_W);
		r.px = OUT_W'(ox);
		r.py = OUT_W'(oy);
		polar_of(ox, oy, r.mag, r.ang);
		acc_x = 0;
		acc_y = 0;
		return 1'b1;
	endfunction

	function automatic jet_t mk_jet(int px, int py, int pt, int eta, bit has_jet, bit last);
		jet_t j;
		j.px      = 17'(px);
		j.py      = 17'(py);
		j.pt      = 16'(pt);
		j.eta     = 10'(eta);
		j.has_jet = has_jet;
		j.last    = last;
		return j;
	endfunction

	// Random jet, with pt and eta often placed right at the current cuts.
	function automatic jet_t random_jet(bit last);
		jet_t j;
		int   v;
		j.px = ($urandom_range(0, 3) == 0) ? 17'(int'($urandom_range(0, 2000)) - 1000)
			: 17'($urandom);
		j.py = ($urandom_range(0, 3) == 0) ? 17'(int'($urandom_range(0, 2000)) - 1000)
			: 17'($urandom);
		case ($urandom_range(0, 3))
			0: begin
				v = int'(cut_pt) + int'($urandom_range(0, 4)) - 2;
				if (v < 0) v = 0;
				if (v > 65535) v = 65535;
				j.pt = 16'(v);
			end
			1: j.pt = 16'($urandom);
			default: j.pt = 16'($urandom_range(0, 2000));
		endcase
		case ($urandom_range(0, 3))
			0: begin
				v = int'(cut_eta) + int'($urandom_range(0, 4)) - 2;
				if (v < 0) v = 0;
				if ($urandom_range(0, 1) == 1) begin
					j.eta = (v > 512) ? -10'sd512 : 10'(-v);
				end else begin
					j.eta = (v > 511) ? 10'sd511 : 10'(v);
				end
			end
			1: j.eta = 10'($urandom);
			default: j.eta = 10'(int'($urandom_range(0, 200)) - 100);
		endcase
		j.has_jet = ($urandom_range(0, 9) != 0);
		j.last    = last;
		return j;
	endfunction

	// Offer one jet item, with an occasional gap ahead of it, and predict on acceptance.
	task automatic send_jet(input jet_t j);
		mht_t r;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			jet_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		jet_ch.valid     <= 1'b1;
		jet_ch.jet_px    <= j.px;
		jet_ch.jet_py    <= j.py;
		jet_ch.jet_pt    <= j.pt;
		jet_ch.jet_eta   <= j.eta;
		jet_ch.jet_valid <= j.has_jet;
		jet_ch.last_jet  <= j.last;
		do @(posedge clk); while (jet_ch.ready !== 1'b1);
		n_jets++;
		if (fold_jet(j, r)) expected_mht.insert(expected_mht.size(), r);
	endtask

	// Stop sending and wait until every expected item has come and the block is quiet.
	task automatic wait_drained();
		jet_ch.valid <= 1'b0;
		while (expected_mht.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both cut registers and one unused index, then drop the write enable.
	task automatic program_cuts(input logic [15:0] pt_word, input logic [15:0] eta_word);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MIN_JET_PT;
		cfg_data  <= pt_word;
		@(posedge clk);
		cfg_index <= REG_MAX_JET_ETA;
		cfg_data  <= eta_word;
		@(posedge clk);
		cfg_index <= ($urandom_range(0, 1) == 1) ? REG_SPARE_2 : REG_SPARE_3;
		cfg_data  <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		cut_pt  = pt_word;
		cut_eta = eta_word[8:0];
		n_cut_settings++;
	endtask

	// Random events of mostly short, sometimes long length, until n_items are sent.
	task automatic run_events(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2: len = $urandom_range(1, 3);
				9: len = $urandom_range(17, 60);
				default: len = $urandom_range(4, 16);
			endcase
			for (int k = 0; k < len; k++) send_jet(random_jet(k == len - 1));
			sent += len;
		end
	endtask

	// Cut edges, empty items, eta of -512, field extremes and angles in three quadrants and along the axes.
	task automatic test_directed_cuts();
		send_jet(mk_jet(0, 0, 0, 0, 0, 1));
		send_jet(mk_jet(100, 7, 120, 0, 1, 0));
		send_jet(mk_jet(100, -50, 121, 0, 1, 0));
		send_jet(mk_jet(0, 0, 65535, 511, 0, 1));
		send_jet(mk_jet(300, 1, 500, 239, 1, 0));
		send_jet(mk_jet(-20, 2, 500, -239, 1, 0));
		send_jet(mk_jet(999, 3, 500, 240, 1, 0));
		send_jet(mk_jet(999, 4, 500, -240, 1, 0));
		send_jet(mk_jet(999, 5, 65535, -512, 1, 0));
		send_jet(mk_jet(999, 6, 65535, 511, 1, 0));
		send_jet(mk_jet(65535, -65536, 65535, 0, 1, 1));
		send_jet(mk_jet(5000, 5000, 900, 10, 0, 0));
		send_jet(mk_jet(-65536, 65535, 200, -1, 1, 1));
		send_jet(mk_jet(1000, 0, 500, 0, 1, 1));
		send_jet(mk_jet(0, 1000, 500, 0, 1, 1));
		send_jet(mk_jet(-1000, 0, 500, 0, 1, 1));
		send_jet(mk_jet(1000, 1000, 500, 0, 1, 1));
		send_jet(mk_jet(1000, -1, 500, 0, 1, 1));
	endtask

	// Drive both sums into their limits, then step back from them.
	task automatic test_saturation();
		for (int k = 0; k < 140; k++) send_jet(mk_jet(-65536, 65535, 65535, 0, 1, 0));
		for (int k = 0; k < 3; k++) send_jet(mk_jet(65535, -65536, 65535, 0, 1, k == 2));
		for (int k = 0; k < 140; k++) send_jet(mk_jet(65535, -65536, 65535, 0, 1, k == 139));
	endtask

	// Random events under several cut settings, the extremes among them.
	task automatic test_cut_sweep();
		logic [15:0] pt_words [7];
		logic [15:0] eta_words [7];
		pt_words  = '{16'd0, 16'd65535, 16'd0, 16'($urandom), 16'($urandom_range(0, 2000)),
			16'd65534, 16'd120};
		eta_words = '{16'd0, 16'd511, 16'hFFFF, 16'($urandom), 16'($urandom_range(0, 511)),
			16'd1, 16'd240};
		for (int s = 0; s < 7; s++) begin
			wait_drained();
			program_cuts(pt_words[s], eta_words[s]);
			idle_en = (s != 3);
			run_events(130);
		end
	endtask

	// Closing items back to back, so that the event queue fills and the input stalls.
	task automatic test_back_to_back_events();
		idle_en = 1'b1;
		for (int k = 0; k < 40; k++) send_jet(random_jet(1'b1));
	endtask

	// Final stretch with no idling on either side.
	task automatic test_quiet_tail();
		idle_en = 1'b0;
		run_events(300);
	endtask

	// Result receiver: random stall bursts while idling is enabled.
	always @(posedge clk) begin
		if (!idle_en) begin
			mht_ch.ready <= 1'b1;
		end else if (rx_stall_left > 0) begin
			mht_ch.ready <= 1'b0;
			rx_stall_left--;
		end else if ($urandom_range(0, 9) == 0) begin
			mht_ch.ready <= 1'b0;
			rx_stall_left = $urandom_range(1, 16) - 1;
		end else begin
			mht_ch.ready <= 1'b1;
		end
	end

	function automatic void check_field(string name, logic [OUT_W-1:0] want,
		logic [OUT_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			n_mismatch++;
		end
	endfunction

	// Compare each accepted result item with the oldest expectation.
	always @(posedge clk) begin
		mht_t want;
		if (arst_n && mht_ch.valid === 1'b1 && mht_ch.ready === 1'b1) begin
			if (expected_mht.size() == 0) begin
				$error("Unexpected missing-HT item: px %0h py %0h", mht_ch.mht_px, mht_ch.mht_py);
				n_mismatch++;
			end else begin
				want = expected_mht.pop_front();
				check_field("mht_px", want.px, mht_ch.mht_px);
				check_field("mht_py", want.py, mht_ch.mht_py);
				check_field("mht_magnitude", want.mag, mht_ch.mht_magnitude);
				check_field("mht_angle", OUT_W'(want.ang), OUT_W'(mht_ch.mht_angle));
				n_events_checked++;
			end
		end
	end

	initial begin
		idle_en          = 1'b1;
		n_jets           = 0;
		n_events_checked = 0;
		n_cut_settings   = 1;
		n_mismatch       = 0;
		cut_pt           = 16'd120;
		cut_eta          = 9'd240;
		acc_x            = 0;
		acc_y            = 0;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_MIN_JET_PT;
		cfg_data         <= '0;
		jet_ch.valid     <= 1'b0;
		jet_ch.jet_px    <= '0;
		jet_ch.jet_py    <= '0;
		jet_ch.jet_pt    <= '0;
		jet_ch.jet_eta   <= '0;
		jet_ch.jet_valid <= 1'b0;
		jet_ch.last_jet  <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cuts();
		test_saturation();
		test_cut_sweep();
		test_back_to_back_events();
		test_quiet_tail();
		wait_drained();

		$display("Sent %0d jet items under %0d cut settings; checked %0d missing-HT items.",
			n_jets, n_cut_settings, n_events_checked);
		$display("Covered cut edges, saturated sums, all quadrants and a full event queue.");
		if (n_mismatch == 0) begin
			$display("missing_ht_accumulator_unit verification clean");
		end else begin
			$display("missing_ht_accumulator_unit verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
sv/mht_pkg.sv
sv/mht_intf.sv
sv/mht_front.sv
sv/mht_queue.sv
sv/mht_cordic.sv
sv/missing_ht_accumulator_unit.sv
tb/sv/tb_top.sv
